/* rtl/lvf_pkg.sv */
// Shared types and constants for the LCD value formatter.
// Depends on nothing; every other file of the block imports it.
package lvf_pkg;

  localparam int LVF_QUEUE_DEPTH = 2;
  localparam int LVF_DIGITS      = 6;

  // Request kinds as carried through the queue
  typedef enum logic [2:0] {
    KIND_COUNT   = 3'd0,
    KIND_VOLTAGE = 3'd1,
    KIND_CURRENT = 3'd2,
    KIND_POWER   = 3'd3,
    KIND_LABELS  = 3'd4,
    KIND_INIT    = 3'd5
  } lvf_kind_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  position;
    logic [31:0] value;
  } lvf_req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [2:0] wait_code;
    logic       last;
  } lvf_rsp_t;

  // Work item handed from front to back: kind, final DDRAM target, BCD digits (d0 lowest)
  typedef struct packed {
    lvf_kind_t                   kind;
    logic [6:0]                  addr;
    logic [LVF_DIGITS-1:0][3:0]  digits;
  } lvf_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lvf_qstat_t;

endpackage

/* rtl/lvf_front.sv */
// Front end: accepts requests, classifies them and converts the value to BCD.
// Depends on lvf_pkg; feeds lvf_fifo.
module lvf_front
  import lvf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  lvf_req_t   req,
  output logic       push,
  output lvf_entry_t entry,
  input  lvf_qstat_t qstat
);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_HOLD} state_t;

  state_t      state, state_next;
  logic [31:0] shreg;
  logic [3:0]  cnt;
  logic        take;
  logic [23:0] bcd1, bcd2;

  // one double-dabble step on six digits; digits above the sixth fall off
  function automatic logic [23:0] dd_step(input logic [23:0] b, input logic bit_in);
    logic [23:0] a;
    a = b;
    for (int i = 0; i < LVF_DIGITS; i++) begin
      if (a[i*4 +: 4] >= 4'd5) a[i*4 +: 4] = a[i*4 +: 4] + 4'd3;
    end
    return {a[22:0], bit_in};
  endfunction

  assign push      = (state == ST_HOLD) && !qstat.full;
  assign req_stall = !((state == ST_IDLE) || push);
  assign take      = req_valid && !req_stall;

  assign bcd1 = dd_step(entry.digits, shreg[31]);
  assign bcd2 = dd_step(bcd1, shreg[30]);

  always_comb begin
    state_next = state;
    case (state)
      ST_CONV: if (cnt == 4'd0) state_next = ST_HOLD;
      ST_HOLD: if (push) state_next = ST_IDLE;
      default: state_next = state;
    endcase
    if (take) begin
      case (req.req_type)
        KIND_COUNT, KIND_VOLTAGE, KIND_CURRENT, KIND_POWER: state_next = ST_CONV;
        KIND_LABELS, KIND_INIT:                             state_next = ST_HOLD;
        default:                                            state_next = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (take) begin
      entry.kind   <= lvf_kind_t'(req.req_type);
      entry.digits <= '0;
      if (req.req_type == KIND_POWER) begin
        entry.addr <= req.position + 7'd7;
        shreg      <= req.value;
        cnt        <= 4'd15;
      end else begin
        entry.addr <= req.position + 7'd4;
        shreg      <= {req.value[15:0], 16'd0};
        cnt        <= 4'd7;
      end
    end else if (state == ST_CONV) begin
      entry.digits <= bcd2;
      shreg        <= {shreg[29:0], 2'b00};
      cnt          <= cnt - 4'd1;
    end
  end

endmodule

/* rtl/lvf_fifo.sv */
// Small work queue between front and back.
// Depends on lvf_pkg.
module lvf_fifo
  import lvf_pkg::*;
#(
  parameter int DEPTH = LVF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lvf_entry_t wr_data,
  input  logic       pop,
  output lvf_entry_t rd_data,
  output lvf_qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lvf_entry_t    mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_data     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CW'(1))
    else $error("queue count did not track push");

endmodule

/* rtl/lvf_back.sv */
// Back end: walks one queued item and emits its nibble writes, one per cycle unless rsp_stall holds them.
// Depends on lvf_pkg; reads from lvf_fifo.
module lvf_back
  import lvf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lvf_entry_t head,
  input  lvf_qstat_t qstat,
  output logic       pop,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output lvf_rsp_t   rsp
);

  lvf_entry_t ent;
  logic       have;
  logic [4:0] idx;
  logic [4:0] idx_init;
  logic [3:0] k, j;
  logic [4:0] len;
  logic [7:0] byte_val;
  logic       rs, hi, raw;
  logic [2:0] low_wait;
  logic [3:0] raw_nib;
  logic [2:0] raw_wait;
  logic       load_out, is_last;
  lvf_rsp_t   nxt;

  function automatic logic [7:0] dchar(input logic [3:0] d);
    return {4'h3, d};
  endfunction

  assign k        = idx[4:1];
  assign j        = k - 4'd2;
  assign hi       = !idx[0];
  assign idx_init = idx - 5'd4;

  always_comb begin
    rs       = 1'b1;
    byte_val = 8'h00;
    low_wait = 3'd0;
    raw      = 1'b0;
    raw_nib  = 4'h0;
    raw_wait = 3'd0;
    len      = 5'd1;
    case (ent.kind)
      KIND_COUNT, KIND_VOLTAGE, KIND_CURRENT, KIND_POWER: begin
        len = (ent.kind == KIND_POWER) ? 5'd20 : 5'd14;
        if (k == 4'd0) begin
          rs = 1'b0; byte_val = 8'h04;
        end else if (k == 4'd1) begin
          rs = 1'b0; byte_val = {1'b1, ent.addr}; low_wait = 3'd1;
        end else begin
          case (ent.kind)
            KIND_COUNT:   byte_val = dchar(ent.digits[j[2:0]]);
            KIND_VOLTAGE: begin
              case (j)
                4'd0:    byte_val = "V";
                4'd1:    byte_val = dchar(ent.digits[0]);
                4'd2:    byte_val = ".";
                4'd3:    byte_val = dchar(ent.digits[1]);
                default: byte_val = dchar(ent.digits[2]);
              endcase
            end
            KIND_CURRENT: begin
              case (j)
                4'd0:    byte_val = "A";
                4'd1:    byte_val = dchar(ent.digits[0]);
                4'd2:    byte_val = dchar(ent.digits[1]);
                4'd3:    byte_val = ".";
                default: byte_val = dchar(ent.digits[2]);
              endcase
            end
            default: begin
              case (j)
                4'd0:    byte_val = "W";
                4'd1:    byte_val = dchar(ent.digits[0]);
                4'd2:    byte_val = dchar(ent.digits[1]);
                4'd3:    byte_val = ".";
                4'd4:    byte_val = dchar(ent.digits[2]);
                4'd5:    byte_val = dchar(ent.digits[3]);
                4'd6:    byte_val = dchar(ent.digits[4]);
                default: byte_val = dchar(ent.digits[5]);
              endcase
            end
          endcase
        end
      end
      KIND_LABELS: begin
        len = 5'd12;
        case (k)
          4'd0:    byte_val = "I";
          4'd1:    byte_val = "N";
          4'd2:    begin rs = 1'b0; byte_val = 8'h80 | 8'd40; low_wait = 3'd1; end
          4'd3:    byte_val = "O";
          4'd4:    byte_val = "U";
          default: byte_val = "T";
        endcase
      end
      KIND_INIT: begin
        len = 5'd14;
        rs  = 1'b0;
        if (idx < 5'd4) begin
          raw = 1'b1;
          case (idx[1:0])
            2'd0:    begin raw_nib = 4'h3; raw_wait = 3'd4; end
            2'd1:    begin raw_nib = 4'h3; raw_wait = 3'd2; end
            2'd2:    begin raw_nib = 4'h3; raw_wait = 3'd1; end
            default: begin raw_nib = 4'h2; raw_wait = 3'd1; end
          endcase
        end else begin
          case (idx_init[4:1])
            4'd0:    begin byte_val = 8'h28; low_wait = 3'd1; end
            4'd1:    begin byte_val = 8'h08; low_wait = 3'd1; end
            4'd2:    begin byte_val = 8'h01; low_wait = 3'd3; end
            4'd3:    begin byte_val = 8'h06; low_wait = 3'd1; end
            default: begin byte_val = 8'h0C; low_wait = 3'd0; end
          endcase
        end
      end
      default: len = 5'd1;
    endcase
  end

  assign is_last        = (idx == len - 5'd1);
  assign nxt.reg_select = rs;
  assign nxt.nibble     = raw ? raw_nib : (hi ? byte_val[7:4] : byte_val[3:0]);
  assign nxt.wait_code  = raw ? raw_wait : (hi ? 3'd0 : low_wait);
  assign nxt.last       = is_last;

  assign load_out = have && (!rsp_valid || !rsp_stall);
  assign pop      = !qstat.empty && (!have || (load_out && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_out)       rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      if (pop)                      have <= 1'b1;
      else if (load_out && is_last) have <= 1'b0;
    end
    if (load_out) begin
      rsp <= nxt;
    end
    // a pop on the last nibble restarts the index for the next item
    if (pop) begin
      ent <= head;
      idx <= '0;
    end else if (load_out) begin
      idx <= idx + 5'd1;
    end
  end

endmodule

/* rtl/lcd_value_formatter_4bit.sv */
// Top level: request in, 4-bit LCD nibble writes out, one nibble per cycle while not stalled.
// The front converts count, voltage, current and power values to BCD at 2 bits per cycle
// and takes the next request only once the converted one is pushed; label and init requests
// skip conversion and are taken one per cycle, in both cases while the queue has room. The
// back end emits 12 to 20 nibbles per request back to back while rsp_stall is low. Sync
// reset empties the queue.
module lcd_value_formatter_4bit
  import lvf_pkg::*;
#(
  parameter int QUEUE_DEPTH = LVF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  // request channel
  input  logic     req_valid,
  output logic     req_stall,
  input  lvf_req_t req,
  // nibble-write channel
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output lvf_rsp_t rsp
);

  // front -> queue
  logic       push;
  lvf_entry_t wr_entry;
  // queue -> back
  logic       pop;
  lvf_entry_t head;
  lvf_qstat_t qstat;

  // Front: classifies the transaction, computes the DDRAM target, runs double dabble.
  // Requests of an unused kind are accepted and dropped here.
  lvf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .entry     (wr_entry),
    .qstat     (qstat)
  );

  // Queue decouples conversion from the nibble sequencer.
  lvf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (head),
    .qstat   (qstat)
  );

  // Back: sequences bytes high nibble first with wait classes; output register
  // lets the next nibble load while the current one is taken.
  lvf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
